// ===== rtl/hid_top_collection_finder_defines.svh =====
// ----------------------------------------------------------------------------
// hid_top_collection_finder_defines
// assertion macros of the collection finder checker file
// ----------------------------------------------------------------------------
`ifndef HID_TOP_COLLECTION_FINDER_DEFINES_SVH
`define HID_TOP_COLLECTION_FINDER_DEFINES_SVH

// same-cycle implication, off while reset is low
`define HIDTCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hidtcf assertion failed");

// next-cycle implication, off while reset is low
`define HIDTCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hidtcf assertion failed");

// next-cycle implication that also checks across reset
`define HIDTCF_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hidtcf reset assertion failed");

`endif

// ===== rtl/hidtcf_pkg.sv =====
// ----------------------------------------------------------------------------
// hidtcf_pkg
// types, codes and helpers of the hid top-level collection finder
// ----------------------------------------------------------------------------
package hidtcf_pkg;

  // collection nesting counter width
  localparam int DEPTH_BITS = 8;

  // configuration register indexes
  localparam logic CFG_WANT_PAGE  = 1'b0;
  localparam logic CFG_WANT_USAGE = 1'b1;

  // item types
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  // item tags
  localparam logic [3:0] TAG_USAGE_PAGE     = 4'h0;
  localparam logic [3:0] TAG_USAGE          = 4'h0;
  localparam logic [3:0] TAG_COLLECTION     = 4'hA;
  localparam logic [3:0] TAG_END_COLLECTION = 4'hC;

  // collection kind
  localparam logic [31:0] COLL_APPLICATION = 32'h0000_0001;

  // parse context that items act on
  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic [15:0]           page;
    logic [31:0]           pend_usage;
    logic                  pend_valid;
    logic                  matched;
  } hidtcf_ctx_t;

  // one result word leaving the parser
  typedef struct packed {
    logic push;
    logic found;
  } hidtcf_res_t;

  // data byte count of a size code
  function automatic logic [2:0] size_of(input logic [1:0] code);
    logic [2:0] sz;
    case (code)
      2'd0:    sz = 3'd0;
      2'd1:    sz = 3'd1;
      2'd2:    sz = 3'd2;
      default: sz = 3'd4;
    endcase
    return sz;
  endfunction

endpackage

// ===== rtl/hidtcf_parser.sv =====
// ----------------------------------------------------------------------------
// hidtcf_parser
// short item parser: prefix decode, data byte gather and item execution
// ----------------------------------------------------------------------------
module hidtcf_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         byte_value,
  input  logic               last_byte,
  input  logic [15:0]        want_page,
  input  logic [15:0]        want_usage,
  output hidtcf_pkg::hidtcf_res_t res
);
  import hidtcf_pkg::*;

  logic        in_data_r, in_data_nxt;
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [1:0]  item_type_r, item_type_nxt;
  logic [3:0]  item_tag_r, item_tag_nxt;
  logic [1:0]  byte_pos_r, byte_pos_nxt;
  logic [31:0] accum_r, accum_nxt;
  hidtcf_ctx_t ctx_r, ctx_nxt;

  logic [2:0]  pre_size;
  logic [31:0] acc_new;
  logic [2:0]  left_new;

  // apply one complete item to the parse context
  function automatic hidtcf_ctx_t run_item(input hidtcf_ctx_t c,
                                           input logic [1:0]  typ,
                                           input logic [3:0]  tag,
                                           input logic [31:0] value,
                                           input logic [15:0] wpage,
                                           input logic [15:0] wusage);
    hidtcf_ctx_t n;
    n = c;
    if (typ == TYPE_GLOBAL && tag == TAG_USAGE_PAGE) begin
      n.page = value[15:0];
    end else if (typ == TYPE_LOCAL && tag == TAG_USAGE) begin
      n.pend_usage = value;
      n.pend_valid = 1'b1;
    end else if (typ == TYPE_MAIN && tag == TAG_COLLECTION) begin
      if (c.depth == '0 && value == COLL_APPLICATION && c.page == wpage &&
          c.pend_valid && c.pend_usage == {16'h0000, wusage}) begin
        n.matched = 1'b1;
      end
      if (c.depth != '1) begin
        n.depth = c.depth + 1'b1;
      end
      n.pend_valid = 1'b0;
      n.pend_usage = '0;
    end else if (typ == TYPE_MAIN && tag == TAG_END_COLLECTION) begin
      if (c.depth != '0) begin
        n.depth = c.depth - 1'b1;
      end
      n.pend_valid = 1'b0;
      n.pend_usage = '0;
    end else if (typ == TYPE_MAIN) begin
      n.pend_valid = 1'b0;
      n.pend_usage = '0;
    end
    return n;
  endfunction

  // data path values for the current byte
  assign pre_size = size_of(byte_value[1:0]);
  assign acc_new  = accum_r | (32'(byte_value) << {byte_pos_r, 3'b000});
  assign left_new = bytes_left_r - 3'd1;

  // next parse state
  always_comb begin
    in_data_nxt    = in_data_r;
    bytes_left_nxt = bytes_left_r;
    item_type_nxt  = item_type_r;
    item_tag_nxt   = item_tag_r;
    byte_pos_nxt   = byte_pos_r;
    accum_nxt      = accum_r;
    ctx_nxt        = ctx_r;
    res            = '0;
    if (accept) begin
      if (!in_data_r) begin
        item_type_nxt = byte_value[3:2];
        item_tag_nxt  = byte_value[7:4];
        if (pre_size == 3'd0) begin
          ctx_nxt = run_item(ctx_r, byte_value[3:2], byte_value[7:4], 32'd0,
                             want_page, want_usage);
        end else begin
          in_data_nxt    = 1'b1;
          bytes_left_nxt = pre_size;
          byte_pos_nxt   = 2'd0;
          accum_nxt      = '0;
        end
      end else begin
        accum_nxt      = acc_new;
        byte_pos_nxt   = byte_pos_r + 2'd1;
        bytes_left_nxt = left_new;
        if (left_new == 3'd0) begin
          in_data_nxt = 1'b0;
          ctx_nxt     = run_item(ctx_r, item_type_r, item_tag_r, acc_new,
                                 want_page, want_usage);
        end
      end
      // end of descriptor: report and start over
      if (last_byte) begin
        res.push       = 1'b1;
        res.found      = ctx_nxt.matched;
        in_data_nxt    = 1'b0;
        bytes_left_nxt = '0;
        item_type_nxt  = '0;
        item_tag_nxt   = '0;
        byte_pos_nxt   = '0;
        accum_nxt      = '0;
        ctx_nxt        = '0;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_data_r    <= 1'b0;
      bytes_left_r <= '0;
      item_type_r  <= '0;
      item_tag_r   <= '0;
      byte_pos_r   <= '0;
      accum_r      <= '0;
      ctx_r        <= '0;
    end else begin
      in_data_r    <= in_data_nxt;
      bytes_left_r <= bytes_left_nxt;
      item_type_r  <= item_type_nxt;
      item_tag_r   <= item_tag_nxt;
      byte_pos_r   <= byte_pos_nxt;
      accum_r      <= accum_nxt;
      ctx_r        <= ctx_nxt;
    end
  end

endmodule

// ===== rtl/hidtcf_outbuf.sv =====
// ----------------------------------------------------------------------------
// hidtcf_outbuf
// result register with one skid entry behind it
// ----------------------------------------------------------------------------
module hidtcf_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  hidtcf_pkg::hidtcf_res_t res,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found
);
  import hidtcf_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_found_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic skid_found_r, skid_found_nxt;

  // move words between skid, output and the parser
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    skid_valid_nxt = skid_valid_r;
    skid_found_nxt = skid_found_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_found_nxt  = skid_found_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res.push;
        out_found_nxt = res.found;
      end
    end else if (res.push) begin
      skid_valid_nxt = 1'b1;
      skid_found_nxt = res.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_found_r  <= out_found_nxt;
    skid_found_r <= skid_found_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

// ===== rtl/hid_top_collection_finder.sv =====
// ----------------------------------------------------------------------------
// hid_top_collection_finder
// finds a top-level application collection with a given usage page and usage
// ----------------------------------------------------------------------------
// Usage: descriptor bytes enter on the in_ channel (in_valid, in_stall,
// in_byte_value, in_last_byte), one byte per word. Short items are parsed as
// they stream by. On the word marked last, one result word with out_found
// leaves on the out_ channel; other bytes give no result.
// Throughput: one byte per cycle while in_stall is low; the whole parse update
// is a single pass of logic on the parse state registers. The result word is
// registered in the result register, or in the skid while that one is stalled.
// The result register has a one-word skid behind it, so bytes keep flowing
// while a result waits. in_stall rises only when both hold a result that the
// receiver has not taken, and falls once out_stall lets one go.
// Reset (rst_n low, synchronous) clears parse state, the result and skid valid
// flags and both cfg registers. cfg_we writes want_page (index 0) or want_usage
// (index 1); write only while no descriptor is in flight.
// ----------------------------------------------------------------------------
module hid_top_collection_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import hidtcf_pkg::*;

  logic [15:0] want_page_r, want_page_nxt;
  logic [15:0] want_usage_r, want_usage_nxt;
  logic        accept;
  logic        full;
  hidtcf_res_t res;

  // configuration registers
  always_comb begin
    want_page_nxt  = want_page_r;
    want_usage_nxt = want_usage_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WANT_PAGE:  want_page_nxt  = cfg_wdata;
        CFG_WANT_USAGE: want_usage_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_page_r  <= '0;
      want_usage_r <= '0;
    end else begin
      want_page_r  <= want_page_nxt;
      want_usage_r <= want_usage_nxt;
    end
  end

  // input handshake
  assign in_stall = full;
  assign accept   = in_valid && !full;

  hidtcf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_value (in_byte_value),
    .last_byte  (in_last_byte),
    .want_page  (want_page_r),
    .want_usage (want_usage_r),
    .res        (res)
  );

  hidtcf_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_found (out_found)
  );

endmodule

// ===== rtl/hidtcf_checker.sv =====
// ----------------------------------------------------------------------------
// hidtcf_checker
// port-level checks of the collection finder, bound to the top level
// ----------------------------------------------------------------------------
`include "hid_top_collection_finder_defines.svh"

module hidtcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_found
);

  // a stalled result word stays offered
  `HIDTCF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // a stalled result word keeps its flag
  `HIDTCF_ASSERT_NEXT(a_out_found_hold, out_valid && out_stall, $stable(out_found))

  // reset empties both the result register and the skid
  `HIDTCF_ASSERT_RST(a_reset_clear, !rst_n, !out_valid && !in_stall)

  // the input stalls only when a result is already waiting
  `HIDTCF_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)

  // a new result follows an accepted last byte
  `HIDTCF_ASSERT_NOW(a_result_from_last, out_valid && !$past(out_valid),
                     $past(in_valid && !in_stall && in_last_byte))

endmodule

bind hid_top_collection_finder hidtcf_checker u_hidtcf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_last_byte  (in_last_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_found     (out_found)
);
